### rtl/tmi_pkg.sv
// Shared constants for the tape machine interpreter: field widths, default
// sizes and the command character codes. No dependencies.
`default_nettype none

package tmi_pkg;

  localparam int TAPE_CELLS_DEF   = 4096;
  localparam int PROGRAM_SIZE_DEF = 4096;
  localparam int LOOP_DEPTH_DEF   = 64;

  localparam int INSTR_W  = 8;
  localparam int PC_OUT_W = 12;
  localparam int BYTE_W   = 8;
  localparam int SKIP_W   = 12;

  localparam logic [SKIP_W-1:0] SKIP_MAX = 12'd4095;

  typedef logic [INSTR_W-1:0] char_t;

  localparam char_t CH_RIGHT = 8'h3E;  // >
  localparam char_t CH_LEFT  = 8'h3C;  // <
  localparam char_t CH_INC   = 8'h2B;  // +
  localparam char_t CH_DEC   = 8'h2D;  // -
  localparam char_t CH_PRINT = 8'h2E;  // .
  localparam char_t CH_OPEN  = 8'h5B;  // [
  localparam char_t CH_CLOSE = 8'h5D;  // ]

endpackage

`default_nettype wire

### rtl/tmi_in_if.sv
// Input channel of the interpreter: one program character per beat.
// Depends on tmi_pkg.
`default_nettype none

interface tmi_in_if;
  logic                        valid;
  logic                        ready;
  logic [tmi_pkg::INSTR_W-1:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

`default_nettype wire

### rtl/tmi_out_if.sv
// Result channel of the interpreter: next fetch address, print byte, fault.
// Depends on tmi_pkg.
`default_nettype none

interface tmi_out_if;
  logic                         valid;
  logic                         ready;
  logic [tmi_pkg::PC_OUT_W-1:0] next_pc;
  logic                         out_valid;
  logic [tmi_pkg::BYTE_W-1:0]   out_byte;
  logic                         fault;

  modport source (output valid, output next_pc, output out_valid, output out_byte,
                  output fault, input ready);
  modport sink   (input valid, input next_pc, input out_valid, input out_byte,
                  input fault, output ready);
endinterface

`default_nettype wire

### rtl/tmi_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle, with a
// write-to-read bypass for same-address collisions. No package dependencies.
`default_nettype none

module tmi_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read sees the write of the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tape_machine_interpreter.sv
// Top level of the tape machine interpreter: execute stage, tape and loop
// stack memories. Depends on tmi_pkg, tmi_in_if, tmi_out_if, tmi_ram.
//
// Takes one program character per beat and returns one result per beat.
// Sustained rate is one character per clock while results are taken: the
// tape and the loop stack are read at the beat's accept edge; the execute
// stage then executes, writes back and loads the result register once that
// register is free or being taken. Read addresses for the next character come
// from the execute stage's updated pointer and stack count, with same-address
// bypass in the memories. After reset the tape is zeroed by a clearing pass
// over all TAPE_CELLS cells (4096 by default), during which no character is
// accepted. The loop stack is not cleared; only pushed entries are ever used.
`default_nettype none

module tape_machine_interpreter #(
  parameter int TAPE_CELLS   = tmi_pkg::TAPE_CELLS_DEF,
  parameter int PROGRAM_SIZE = tmi_pkg::PROGRAM_SIZE_DEF,
  parameter int LOOP_DEPTH   = tmi_pkg::LOOP_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  tmi_in_if.sink    in_ch,
  tmi_out_if.source out_ch
);

  localparam int DW  = $clog2(TAPE_CELLS);
  localparam int PW  = $clog2(PROGRAM_SIZE);
  localparam int SIW = $clog2(LOOP_DEPTH);
  localparam int SCW = $clog2(LOOP_DEPTH + 1);
  localparam int BW  = tmi_pkg::BYTE_W;
  localparam int KW  = tmi_pkg::SKIP_W;

  // architectural state
  logic [DW-1:0]  dp;
  logic [PW-1:0]  pc;
  logic [SCW-1:0] sc;
  logic [KW-1:0]  skip;

  // execute stage
  logic                  b_valid;
  tmi_pkg::char_t        b_instr;

  // result register
  logic                         o_valid;
  logic [tmi_pkg::PC_OUT_W-1:0] o_pc;
  logic                         o_print;
  logic [BW-1:0]                o_byte;
  logic                         o_fault;

  // clearing pass
  logic          clr_busy;
  logic [DW-1:0] clr_addr;

  logic accept;
  logic b_adv;

  logic [DW-1:0]  dp_next;
  logic [PW-1:0]  pc_next;
  logic [SCW-1:0] sc_next;
  logic [KW-1:0]  skip_next;
  logic [PW-1:0]  pc_inc;
  logic [PW-1:0]  top_inc;
  logic [SCW-1:0] sc_top;

  logic [BW-1:0] cell_data;
  logic [PW-1:0] top;
  logic          tape_we;
  logic [BW-1:0] tape_wdata;
  logic          stk_we;
  logic          res_print;
  logic [BW-1:0] res_byte;
  logic          res_fault;

  logic          ram_we;
  logic [DW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;

  assign b_adv       = b_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !clr_busy && (!b_valid || b_adv);
  assign accept      = in_ch.valid && in_ch.ready;

  assign pc_inc  = (pc == PW'(PROGRAM_SIZE - 1)) ? '0 : pc + PW'(1);
  assign top_inc = (top == PW'(PROGRAM_SIZE - 1)) ? '0 : top + PW'(1);

  always_comb begin
    dp_next    = dp;
    pc_next    = pc;
    sc_next    = sc;
    skip_next  = skip;
    tape_we    = 1'b0;
    tape_wdata = cell_data;
    stk_we     = 1'b0;
    res_print  = 1'b0;
    res_byte   = '0;
    res_fault  = 1'b0;
    if (b_adv) begin
      pc_next = pc_inc;
      if (skip != '0) begin
        // skip mode: only bracket nesting is tracked
        if (b_instr == tmi_pkg::CH_OPEN) begin
          if (skip != tmi_pkg::SKIP_MAX) begin
            skip_next = skip + KW'(1);
          end
        end else if (b_instr == tmi_pkg::CH_CLOSE) begin
          skip_next = skip - KW'(1);
        end
      end else begin
        case (b_instr)
          tmi_pkg::CH_RIGHT: begin
            dp_next = (dp == DW'(TAPE_CELLS - 1)) ? '0 : dp + DW'(1);
          end
          tmi_pkg::CH_LEFT: begin
            dp_next = (dp == '0) ? DW'(TAPE_CELLS - 1) : dp - DW'(1);
          end
          tmi_pkg::CH_INC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_data + BW'(1);
          end
          tmi_pkg::CH_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_data - BW'(1);
          end
          tmi_pkg::CH_PRINT: begin
            res_print = 1'b1;
            res_byte  = cell_data;
          end
          tmi_pkg::CH_OPEN: begin
            if (cell_data == '0) begin
              skip_next = KW'(1);
            end else if (sc == SCW'(LOOP_DEPTH)) begin
              res_fault = 1'b1;
            end else begin
              stk_we  = 1'b1;
              sc_next = sc + SCW'(1);
            end
          end
          tmi_pkg::CH_CLOSE: begin
            if (sc == '0) begin
              res_fault = 1'b1;
            end else if (cell_data != '0) begin
              pc_next = top_inc;
            end else begin
              sc_next = sc - SCW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign sc_top = sc_next - SCW'(1);

  assign ram_we    = clr_busy || tape_we;
  assign ram_waddr = clr_busy ? clr_addr : dp;
  assign ram_wdata = clr_busy ? '0 : tape_wdata;

  tmi_ram #(
    .DEPTH (TAPE_CELLS),
    .WIDTH (BW)
  ) u_tape (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (dp_next),
    .rd_data (cell_data)
  );

  tmi_ram #(
    .DEPTH (LOOP_DEPTH),
    .WIDTH (PW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (sc[SIW-1:0]),
    .wr_data (pc),
    .rd_en   (accept),
    .rd_addr (sc_top[SIW-1:0]),
    .rd_data (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dp       <= '0;
      pc       <= '0;
      sc       <= '0;
      skip     <= '0;
      b_valid  <= 1'b0;
      o_valid  <= 1'b0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else begin
      dp   <= dp_next;
      pc   <= pc_next;
      sc   <= sc_next;
      skip <= skip_next;
      if (clr_busy) begin
        clr_addr <= clr_addr + DW'(1);
        if (clr_addr == DW'(TAPE_CELLS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_instr <= in_ch.instruction;
    end
    if (b_adv) begin
      o_pc    <= tmi_pkg::PC_OUT_W'(pc_next);
      o_print <= res_print;
      o_byte  <= res_byte;
      o_fault <= res_fault;
    end
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.next_pc   = o_pc;
  assign out_ch.out_valid = o_print;
  assign out_ch.out_byte  = o_byte;
  assign out_ch.fault     = o_fault;

endmodule

`default_nettype wire

### rtl/tmi_checker.sv
// Port-level checks for the tape machine interpreter, bound to its top level.
// Depends on tmi_pkg and tape_machine_interpreter.
`default_nettype none

module tmi_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_ready,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic [tmi_pkg::PC_OUT_W-1:0] next_pc,
  input wire logic                         out_valid,
  input wire logic [tmi_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                         fault
);

  // tape clearing holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input accepted during tape clearing");

  a_byte_zero_when_silent: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (out_byte == '0))
    else $error("nonzero out_byte without print");

  a_print_xor_fault: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && fault))
    else $error("print and fault in one result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(next_pc) && $stable(fault)))
    else $error("stalled result changed");

endmodule

bind tape_machine_interpreter tmi_checker u_tmi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .res_valid (out_ch.valid),
  .res_ready (out_ch.ready),
  .next_pc   (out_ch.next_pc),
  .out_valid (out_ch.out_valid),
  .out_byte  (out_ch.out_byte),
  .fault     (out_ch.fault)
);

`default_nettype wire

### tb/sv/tmi_trace_compare.sv
// Result checker for the tape machine interpreter: predicts each step from the
// accepted characters and compares the result beats in order.
// Depends on tmi_pkg, tmi_in_if, tmi_out_if.
module tmi_trace_compare (
  input  logic clk,
  input  logic rst,
  tmi_in_if    in_ch,
  tmi_out_if   out_ch,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import tmi_pkg::*;

  localparam int CELLS  = TAPE_CELLS_DEF;
  localparam int LDEPTH = LOOP_DEPTH_DEF;

  typedef struct packed {
    logic [PC_OUT_W-1:0] next_pc;
    logic                out_valid;
    logic [BYTE_W-1:0]   out_byte;
    logic                fault;
  } step_result_t;

  logic [BYTE_W-1:0]   tape_mem  [CELLS];
  logic [PC_OUT_W-1:0] loop_addr [LDEPTH];
  logic [PC_OUT_W-1:0] ptr;
  logic [PC_OUT_W-1:0] pc;
  logic [SKIP_W-1:0]   skip_level;
  int                  depth_used;
  step_result_t        step_q [$];

  // Executes one character on the shadow machine and returns its result.
  function automatic step_result_t exec_char(input char_t c);
    step_result_t        r;
    logic [PC_OUT_W-1:0] nxt;
    r   = '0;
    nxt = pc + PC_OUT_W'(1);
    if (skip_level != '0) begin
      // skipping: only brackets move the nesting level
      if (c == CH_OPEN) begin
        if (skip_level != SKIP_MAX) skip_level = skip_level + SKIP_W'(1);
      end else if (c == CH_CLOSE) begin
        skip_level = skip_level - SKIP_W'(1);
      end
    end else begin
      case (c)
        CH_RIGHT: ptr = ptr + PC_OUT_W'(1);
        CH_LEFT:  ptr = ptr - PC_OUT_W'(1);
        CH_INC:   tape_mem[ptr] = tape_mem[ptr] + BYTE_W'(1);
        CH_DEC:   tape_mem[ptr] = tape_mem[ptr] - BYTE_W'(1);
        CH_PRINT: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape_mem[ptr];
        end
        CH_OPEN: begin
          if (tape_mem[ptr] == '0) begin
            skip_level = SKIP_W'(1);
          end else if (depth_used >= LDEPTH) begin
            r.fault = 1'b1;
          end else begin
            loop_addr[depth_used] = pc;
            depth_used++;
          end
        end
        CH_CLOSE: begin
          if (depth_used == 0) begin
            r.fault = 1'b1;
          end else if (tape_mem[ptr] != '0) begin
            nxt = loop_addr[depth_used-1] + PC_OUT_W'(1);
          end else begin
            depth_used--;
          end
        end
        default: ;
      endcase
    end
    pc        = nxt;
    r.next_pc = nxt;
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    step_result_t got;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) tape_mem[i] = '0;
      ptr        = '0;
      pc         = '0;
      skip_level = '0;
      depth_used = 0;
      step_q.delete();
      fails      = 0;
    end else begin
      // result side first: a beat cannot leave on the edge it enters
      if (out_ch.valid && out_ch.ready) begin
        got.next_pc   = out_ch.next_pc;
        got.out_valid = out_ch.out_valid;
        got.out_byte  = out_ch.out_byte;
        got.fault     = out_ch.fault;
        if (step_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result beat next_pc %h out_valid %b out_byte %h fault %b",
                     $realtime, got.next_pc, got.out_valid, got.out_byte, got.fault);
        end else begin
          want = step_q.pop_front();
          if (want.next_pc !== got.next_pc || want.out_valid !== got.out_valid ||
              want.out_byte !== got.out_byte || want.fault !== got.fault) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch exp/act next_pc %h/%h out_valid %b/%b out_byte %h/%h fault %b/%b",
                       $realtime, want.next_pc, got.next_pc, want.out_valid, got.out_valid,
                       want.out_byte, got.out_byte, want.fault, got.fault);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) step_q.push_back(exec_char(in_ch.instruction));
    end
    pending = step_q.size();
  end

endmodule

### tb/sv/tb_tape_machine_interpreter.sv
// Testbench top for the tape machine interpreter: clock, reset, character
// stimulus and result-side stalls. Checking is done in tmi_trace_compare.
// Depends on tmi_pkg, tmi_in_if, tmi_out_if, tape_machine_interpreter.
module tb_tape_machine_interpreter;
  timeunit 1ns;
  timeprecision 1ps;

  import tmi_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1135;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;
  bit   no_gaps;

  char_t body_ops [8] = '{CH_INC, CH_INC, CH_DEC, CH_DEC, CH_RIGHT, CH_LEFT, CH_PRINT, CH_PRINT};
  char_t directed [27] = '{
    CH_PRINT, CH_DEC, CH_PRINT, CH_INC, CH_INC, CH_PRINT,  // cell wrap both ways
    CH_LEFT, CH_INC, CH_PRINT, CH_RIGHT,                   // pointer wrap below zero and back
    CH_CLOSE,                                              // close on an empty stack
    CH_DEC, CH_OPEN, CH_OPEN, CH_PRINT, CH_INC, CH_CLOSE, CH_CLOSE,  // nested skip
    CH_INC, CH_OPEN, CH_PRINT, CH_CLOSE, CH_DEC, CH_CLOSE, // push, jump back, pop
    8'h00, 8'hFF, 8'h7F
  };

  tmi_in_if  in_ch ();
  tmi_out_if out_ch ();

  tape_machine_interpreter dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tmi_trace_compare cmp (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_char(input char_t c);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.instruction <= c;
    do @(posedge clk); while (!in_ch.ready);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Mostly balanced bracket programs with random bodies, plus noise bytes
  // and stray bracket runs.
  task automatic run_random(input int n);
    char_t frag [$];
    int    done;
    int    depth;
    int    len;
    int    kind;
    int    roll;
    bit    paused;
    done   = 0;
    paused = 1'b0;
    while (done < n) begin
      frag.delete();
      depth = 0;
      kind  = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(3, 30);
        for (int i = 0; i < len; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 15 && depth < 6) begin
            frag.push_back(CH_OPEN);
            depth++;
          end else if (roll < 30 && depth > 0) begin
            frag.push_back(CH_CLOSE);
            depth--;
          end else if (roll < 37) begin
            frag.push_back(char_t'($urandom_range(0, 255)));
          end else begin
            frag.push_back(body_ops[$urandom_range(0, 7)]);
          end
        end
        for (; depth > 0; depth--) frag.push_back(CH_CLOSE);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 8)) frag.push_back(char_t'($urandom_range(0, 255)));
      end else begin
        roll = $urandom_range(0, 1);
        repeat ($urandom_range(1, 8)) frag.push_back(roll ? CH_OPEN : CH_CLOSE);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      foreach (frag[i]) begin
        send_char(frag[i]);
        done++;
      end
      if (!paused && done >= n / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  // Result side: random stalls in stretches, and periodic long hold-offs
  // that back the block up into its input.
  initial begin
    int beats;
    int hold_left;
    int stall_left;
    int mode_left;
    int hold_at;
    bit steady;
    beats      = 0;
    hold_left  = 0;
    stall_left = 0;
    mode_left  = 0;
    hold_at    = 150;
    steady     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_ch.valid && out_ch.ready) beats++;
        if (mode_left == 0) begin
          steady    = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        if (hold_left == 0 && beats >= hold_at) begin
          hold_left = 400;
          hold_at   = hold_at + 600;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    no_gaps = 1'b0;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.instruction <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_char(directed[i]);

    // fresh cell 1 set nonzero: fill the loop stack past its depth, then
    // clear the cell and pop everything plus three
    send_char(CH_RIGHT);
    send_char(CH_INC);
    repeat (66) send_char(CH_OPEN);
    send_char(CH_CLOSE);
    send_char(CH_DEC);
    repeat (67) send_char(CH_CLOSE);
    drain();

    // deep skip nesting back to back, unwinding to exactly zero
    no_gaps = 1'b1;
    send_char(CH_OPEN);
    repeat (24) send_char(CH_OPEN);
    repeat (25) send_char(CH_CLOSE);
    send_char(CH_PRINT);
    no_gaps = 1'b0;
    drain();

    run_random(RANDOM_ITEMS);
    drain();
    repeat (16) @(posedge clk);

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tmi_pkg.sv
rtl/tmi_in_if.sv
rtl/tmi_out_if.sv
rtl/tmi_ram.sv
rtl/tape_machine_interpreter.sv
rtl/tmi_checker.sv
tb/sv/tmi_trace_compare.sv
tb/sv/tb_tape_machine_interpreter.sv
